/* rtl/core/doppler_variable_delay_interp_top_macros.svh */
// Assertion macros shared by the block's modules.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef DOPPLER_VARIABLE_DELAY_INTERP_TOP_MACROS_SVH
`define DOPPLER_VARIABLE_DELAY_INTERP_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define DVDI_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("assertion failed");
`define DVDI_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define DVDI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define DVDI_ASSERT(lbl, prop)
`define DVDI_ASSERT_IMPL(lbl, ante, cons)
`define DVDI_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/core/dvdi_pkg.sv */
package dvdi_pkg;

    localparam int DEF_HISTORY_DEPTH    = 8192;
    localparam int DEF_SINE_TABLE_DEPTH = 1024;

    localparam int SAMPLE_W = 24;
    localparam int ARR_W    = 32;
    localparam int DVD_W    = 64;
    localparam int DVS_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    localparam logic [31:0] PI_Q30  = 32'd3373259426;
    localparam logic [30:0] ONE_Q30 = 31'd1073741824;

    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VANISH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DLY_DIST = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INFINITE = 3'd5;

    typedef enum logic [5:0] {
        S_IDLE, S_A_MUL, S_A_GET, S_A2_MUL, S_A2_GET,
        S_T_MUL, S_T_DIV, S_T_WAIT, S_S_MUL, S_S_GET,
        S_H_MUL, S_H_GET, S_D_MUL, S_D_GET, S_Y_MUL, S_Y_GET,
        S_PUSH, S_RD, S_CMP,
        S_IL_MUL, S_IL_DIV, S_IL_WAIT, S_IR_MUL, S_IR_DIV, S_IR_WAIT,
        S_VOL, S_VL_MUL, S_VL_DIV, S_VL_WAIT, S_VR_MUL, S_VR_DIV, S_VR_WAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [ARR_W-1:0]    arr;
        logic [SAMPLE_W-1:0] l;
        logic [SAMPLE_W-1:0] r;
    } t_entry;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } t_div_rsp;

    // Taylor series divisions by 72, 42, 20 and 6, innermost term first:
    // strip the power of two, then multiply by the reciprocal of 9, 21, 5 or 3
    function automatic logic [31:0] term_pre(input logic [1:0] idx, input logic [31:0] v);
        logic [31:0] w;
        unique case (idx)
            2'd0: w = v >> 3;
            2'd1: w = v >> 1;
            2'd2: w = v >> 2;
            default: w = v >> 1;
        endcase
        return w;
    endfunction

    function automatic logic [31:0] term_magic(input logic [1:0] idx);
        logic [31:0] m;
        unique case (idx)
            2'd0: m = 32'd3817748708;
            2'd1: m = 32'd3272356036;
            2'd2: m = 32'd3435973837;
            default: m = 32'd2863311531;
        endcase
        return m;
    endfunction

    function automatic logic [30:0] term_quot(input logic [1:0] idx, input logic [63:0] p);
        logic [30:0] q;
        unique case (idx)
            2'd0: q = 31'(p >> 35);
            2'd1: q = 31'(p >> 36);
            2'd2: q = 31'(p >> 34);
            default: q = 31'(p >> 33);
        endcase
        return q;
    endfunction

endpackage

/* rtl/core/dvdi_ram.sv */
module dvdi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/dvdi_mul.sv */
module dvdi_mul
    import dvdi_pkg::*;
(
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_prod
);

    logic [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_a) * 64'(i_b);
    end

    assign o_prod = r_prod;

endmodule

/* rtl/core/dvdi_div.sv */
`include "doppler_variable_delay_interp_top_macros.svh"
module dvdi_div
    import dvdi_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DVD_W-1:0] r_quo, n_quo;
    logic [DVS_W-1:0] r_div, n_div;
    logic [DVS_W:0]   trial;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_div  = r_div;
        trial  = {r_rem, r_quo[DVD_W-1]};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(DVD_W);
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_div  = i_req.divisor;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_div}) begin
                n_rem = DVS_W'(trial - {1'b0, r_div});
                n_quo = {r_quo[DVD_W-2:0], 1'b1};
            end else begin
                n_rem = trial[DVS_W-1:0];
                n_quo = {r_quo[DVD_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    `DVDI_ASSERT_IMPL(a_start_when_free, i_req.start, !r_busy)
    `DVDI_ASSERT_NEXT(a_done_pulse, r_done, !r_done)
    `DVDI_ASSERT_IMPL(a_busy_count, r_busy, r_cnt != '0)

endmodule

/* rtl/core/doppler_variable_delay_interp_top.sv */
// Doppler variable delay line for one stereo pair per item. An item at the first sample of
// an LFO period is written to the history and passed straight out; any other item also runs
// the LFO and delay arithmetic and scans the history for the bracketing pair, and may skip
// interpolation or volume scaling. A single 32x32 multiplier does all products, the Taylor
// series divisions by constants use reciprocal multiplication, and a one-bit-per-cycle
// divider does the four remaining divisions, each fed by a product from the multiplier. The
// history is read one entry at a time through the single read port of its RAM.
// The history RAM needs no clearing after reset; a new item is taken while a finished
// result still waits in the output register.
`include "doppler_variable_delay_interp_top_macros.svh"
module doppler_variable_delay_interp_top
    import dvdi_pkg::*;
#(
    parameter int HISTORY_DEPTH    = DEF_HISTORY_DEPTH,
    parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DAT_W-1:0]        i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic signed [SAMPLE_W-1:0]  i_left_in,
    input  logic signed [SAMPLE_W-1:0]  i_right_in,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [SAMPLE_W-1:0]  o_left_out,
    output logic signed [SAMPLE_W-1:0]  o_right_out,
    output logic                        o_delay_clipped
);

    localparam int PTR_W  = $clog2(HISTORY_DEPTH);
    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int SINE_W = $clog2(SINE_TABLE_DEPTH);
    localparam int SHIFT  = 32 - SINE_W;
    localparam logic [32:0] LIM = 33'(HISTORY_DEPTH - 2) << 12;

    function automatic logic [PTR_W-1:0] wrap_idx(input logic [CNT_W:0] v);
        logic [CNT_W:0] w;
        w = (v >= (CNT_W+1)'(HISTORY_DEPTH)) ? v - (CNT_W+1)'(HISTORY_DEPTH) : v;
        return w[PTR_W-1:0];
    endfunction

    t_state r_state, n_state;

    logic [19:0] r_period;
    logic [31:0] r_step;
    logic [15:0] r_maxd, r_vp, r_dpd;
    logic        r_inf;

    logic [19:0]      r_counter;
    logic [31:0]      r_phase;
    logic [PTR_W-1:0] r_oldest;
    logic [CNT_W-1:0] r_count;

    logic [SAMPLE_W-1:0] r_l, r_r;
    logic [31:0]      r_a, r_a2, r_arr;
    logic [30:0]      r_t, r_s;
    logic [1:0]       r_term;
    logic [16:0]      r_h;
    logic [15:0]      r_d;
    logic             r_clip;
    logic [CNT_W-1:0] r_scan;
    t_entry           r_lo, r_hi;
    logic [SAMPLE_W-1:0] r_ol, r_or;

    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_l, r_out_r;
    logic                r_out_clip;

    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    t_div_req    div_req;
    t_div_rsp    div_rsp;
    logic        ram_we;
    logic [PTR_W-1:0] ram_waddr, ram_raddr;
    t_entry      ram_wdata, ram_rdata;
    logic [$bits(t_entry)-1:0] ram_rbits;
    logic        in_ready, out_load;

    logic [31:0]      c12, x, num, den;
    logic [SINE_W:0]  kk;
    logic             full, hit, vol_on;
    logic [PTR_W-1:0] p_old, push_idx;
    logic [CNT_W-1:0] p_cnt;
    logic [24:0]      diff_l, diff_r, mag_l, mag_r, ext_ol, ext_or, mag_ol, mag_or;
    logic [15:0]      gain;
    logic [27:0]      dly28;
    logic [32:0]      dly, arr_sum;

    assign ram_rdata = t_entry'(ram_rbits);
    assign c12 = {r_counter, 12'b0};

    always_comb begin
        kk = {1'b0, r_phase[31 -: SINE_W]};
        if (kk > (SINE_W+1)'(SINE_TABLE_DEPTH / 2)) begin
            kk = (SINE_W+1)'(SINE_TABLE_DEPTH) - kk;
        end
        x = 32'(kk) << SHIFT;
    end

    assign full     = r_count >= CNT_W'(HISTORY_DEPTH);
    assign p_old    = full ? wrap_idx((CNT_W+1)'(r_oldest) + (CNT_W+1)'(1)) : r_oldest;
    assign p_cnt    = full ? CNT_W'(HISTORY_DEPTH - 1) : r_count;
    assign push_idx = wrap_idx((CNT_W+1)'(p_old) + (CNT_W+1)'(p_cnt));

    assign hit = (ram_rdata.arr >= c12) || (r_scan == r_count - 1'b1);
    assign num = c12 - r_lo.arr;
    assign den = r_hi.arr - r_lo.arr;

    assign diff_l = {r_hi.l[SAMPLE_W-1], r_hi.l} - {r_lo.l[SAMPLE_W-1], r_lo.l};
    assign diff_r = {r_hi.r[SAMPLE_W-1], r_hi.r} - {r_lo.r[SAMPLE_W-1], r_lo.r};
    assign mag_l  = diff_l[24] ? -diff_l : diff_l;
    assign mag_r  = diff_r[24] ? -diff_r : diff_r;
    assign ext_ol = {r_ol[SAMPLE_W-1], r_ol};
    assign ext_or = {r_or[SAMPLE_W-1], r_or};
    assign mag_ol = ext_ol[24] ? -ext_ol : ext_ol;
    assign mag_or = ext_or[24] ? -ext_or : ext_or;
    assign gain   = r_vp - r_d;
    assign vol_on = !r_inf && (r_vp != 16'd0) && (r_d <= r_vp);

    assign dly28   = prod[31:4];
    assign dly     = (33'(dly28) > LIM) ? LIM : 33'(dly28);
    assign arr_sum = {1'b0, c12} + dly;

    assign ram_wdata = '{arr: r_arr, l: r_l, r: r_r};
    assign out_load  = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (i_in_valid) n_state = (r_counter == 20'd0) ? S_PUSH : S_A_MUL;
            S_A_MUL:   n_state = S_A_GET;
            S_A_GET:   n_state = S_A2_MUL;
            S_A2_MUL:  n_state = S_A2_GET;
            S_A2_GET:  n_state = S_T_MUL;
            S_T_MUL:   n_state = S_T_DIV;
            S_T_DIV:   n_state = S_T_WAIT;
            S_T_WAIT:  n_state = (r_term == 2'd3) ? S_S_MUL : S_T_MUL;
            S_S_MUL:   n_state = S_S_GET;
            S_S_GET:   n_state = S_H_MUL;
            S_H_MUL:   n_state = S_H_GET;
            S_H_GET:   n_state = S_D_MUL;
            S_D_MUL:   n_state = S_D_GET;
            S_D_GET:   n_state = S_Y_MUL;
            S_Y_MUL:   n_state = S_Y_GET;
            S_Y_GET:   n_state = S_PUSH;
            S_PUSH:    n_state = (r_counter == 20'd0) ? S_OUT : S_RD;
            S_RD:      n_state = S_CMP;
            S_CMP:     if (hit) n_state = (r_scan == '0) ? S_VOL : S_IL_MUL;
                       else n_state = S_RD;
            S_IL_MUL:  n_state = S_IL_DIV;
            S_IL_DIV:  n_state = S_IL_WAIT;
            S_IL_WAIT: if (div_rsp.done) n_state = S_IR_MUL;
            S_IR_MUL:  n_state = S_IR_DIV;
            S_IR_DIV:  n_state = S_IR_WAIT;
            S_IR_WAIT: if (div_rsp.done) n_state = S_VOL;
            S_VOL:     n_state = vol_on ? S_VL_MUL : S_OUT;
            S_VL_MUL:  n_state = S_VL_DIV;
            S_VL_DIV:  n_state = S_VL_WAIT;
            S_VL_WAIT: if (div_rsp.done) n_state = S_VR_MUL;
            S_VR_MUL:  n_state = S_VR_DIV;
            S_VR_DIV:  n_state = S_VR_WAIT;
            S_VR_WAIT: if (div_rsp.done) n_state = S_OUT;
            S_OUT:     if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        div_req   = '0;
        ram_we    = 1'b0;
        ram_waddr = push_idx;
        ram_raddr = wrap_idx((CNT_W+1)'(r_oldest) + (CNT_W+1)'(r_scan));
        in_ready  = 1'b0;
        unique case (r_state)
            S_IDLE:   in_ready = 1'b1;
            S_A_MUL:  begin mul_a = x;        mul_b = PI_Q30;     end
            S_A2_MUL: begin mul_a = r_a;      mul_b = r_a;        end
            S_T_MUL:  begin mul_a = r_a2;     mul_b = 32'(r_t);   end
            S_T_DIV: begin
                mul_a = term_pre(r_term, prod[61:30]);
                mul_b = term_magic(r_term);
            end
            S_S_MUL:  begin mul_a = r_a;      mul_b = 32'(r_t);   end
            S_H_MUL:  begin mul_a = 32'(r_s); mul_b = 32'(r_s);   end
            S_D_MUL:  begin mul_a = 32'(r_h); mul_b = 32'(r_maxd); end
            S_Y_MUL:  begin mul_a = 32'(r_d); mul_b = 32'(r_dpd); end
            S_IL_MUL: begin mul_a = 32'(mag_l); mul_b = num; end
            S_IR_MUL: begin mul_a = 32'(mag_r); mul_b = num; end
            S_VL_MUL: begin mul_a = 32'(mag_ol); mul_b = 32'(gain); end
            S_VR_MUL: begin mul_a = 32'(mag_or); mul_b = 32'(gain); end
            S_IL_DIV, S_IR_DIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = prod;
                div_req.divisor  = den;
            end
            S_VL_DIV, S_VR_DIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = prod;
                div_req.divisor  = 32'(r_vp);
            end
            S_PUSH:   ram_we = 1'b1;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= 20'd96000;
            r_step   <= 32'd44739;
            r_maxd   <= 16'd25600;
            r_vp     <= 16'd12800;
            r_dpd    <= 16'd35825;
            r_inf    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PERIOD:   r_period <= i_cfg_data[19:0];
                CFG_STEP:     r_step   <= i_cfg_data;
                CFG_MAX_DIST: r_maxd   <= i_cfg_data[15:0];
                CFG_VANISH:   r_vp     <= i_cfg_data[15:0];
                CFG_DLY_DIST: r_dpd    <= i_cfg_data[15:0];
                CFG_INFINITE: r_inf    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_counter   <= '0;
            r_phase     <= '0;
            r_oldest    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_PUSH) begin
                r_oldest <= p_old;
                r_count  <= p_cnt + 1'b1;
            end else if (r_state == S_CMP && hit && r_scan != '0) begin
                r_oldest <= wrap_idx((CNT_W+1)'(r_oldest) + (CNT_W+1)'(r_scan) -
                                     (CNT_W+1)'(1));
                r_count  <= r_count - (r_scan - 1'b1);
            end else if (out_load) begin
                if (21'(r_counter) + 21'd1 > 21'(r_period)) begin
                    r_counter <= '0;
                    r_phase   <= '0;
                    r_oldest  <= '0;
                    r_count   <= '0;
                end else begin
                    r_counter <= r_counter + 1'b1;
                    r_phase   <= r_phase + r_step;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_l    <= i_left_in;
                r_r    <= i_right_in;
                r_ol   <= i_left_in;
                r_or   <= i_right_in;
                r_clip <= 1'b0;
                r_arr  <= '0;
                r_scan <= '0;
            end
            S_A_GET:  r_a <= prod[63:32];
            S_A2_GET: begin
                r_a2   <= prod[61:30];
                r_t    <= ONE_Q30;
                r_term <= 2'd0;
            end
            S_T_WAIT: begin
                r_t    <= ONE_Q30 - term_quot(r_term, prod);
                r_term <= r_term + 1'b1;
            end
            S_S_GET:  r_s <= (prod[63:30] > 34'(ONE_Q30)) ? ONE_Q30 : prod[60:30];
            S_H_GET:  r_h <= (prod[63:44] > 20'd65536) ? 17'd65536 : prod[60:44];
            S_D_GET:  r_d <= 16'((prod[31:0] + 32'd32768) >> 16);
            S_Y_GET: begin
                r_clip <= 33'(dly28) > LIM;
                r_arr  <= arr_sum[32] ? 32'hFFFF_FFFF : arr_sum[31:0];
            end
            S_CMP: begin
                if (hit) begin
                    r_hi <= ram_rdata;
                    r_ol <= ram_rdata.l;
                    r_or <= ram_rdata.r;
                end else begin
                    r_lo   <= ram_rdata;
                    r_scan <= r_scan + 1'b1;
                end
            end
            S_IL_WAIT: if (div_rsp.done) begin
                r_ol <= SAMPLE_W'({{2{r_lo.l[SAMPLE_W-1]}}, r_lo.l} +
                        (diff_l[24] ? -26'(div_rsp.quotient[24:0])
                                    : 26'(div_rsp.quotient[24:0])));
            end
            S_IR_WAIT: if (div_rsp.done) begin
                r_or <= SAMPLE_W'({{2{r_lo.r[SAMPLE_W-1]}}, r_lo.r} +
                        (diff_r[24] ? -26'(div_rsp.quotient[24:0])
                                    : 26'(div_rsp.quotient[24:0])));
            end
            S_VL_WAIT: if (div_rsp.done) begin
                r_ol <= ext_ol[24] ? -div_rsp.quotient[SAMPLE_W-1:0]
                                   : div_rsp.quotient[SAMPLE_W-1:0];
            end
            S_VR_WAIT: if (div_rsp.done) begin
                r_or <= ext_or[24] ? -div_rsp.quotient[SAMPLE_W-1:0]
                                   : div_rsp.quotient[SAMPLE_W-1:0];
            end
            default: begin
            end
        endcase
        if (out_load) begin
            r_out_l    <= r_ol;
            r_out_r    <= r_or;
            r_out_clip <= r_clip;
        end
    end

    dvdi_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    dvdi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    dvdi_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rbits)
    );

    assign o_in_ready      = in_ready;
    assign o_out_valid     = r_out_valid;
    assign o_left_out      = r_out_l;
    assign o_right_out     = r_out_r;
    assign o_delay_clipped = r_out_clip;

    `DVDI_ASSERT(a_count_bound, r_count <= CNT_W'(HISTORY_DEPTH))
    `DVDI_ASSERT_IMPL(a_scan_in_range, r_state == S_RD, r_scan < r_count)
    `DVDI_ASSERT_NEXT(a_accept_busy, i_in_valid && o_in_ready, r_state != S_IDLE)

endmodule
